@@ rtl/gpdp_pkg.sv @@
// Types and constants shared by the gray pixel depth packer.
`timescale 1ns / 1ps
`default_nettype none

package gpdp_pkg;

    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned SLOT_W  = 3;

    localparam logic [PIXEL_W-1:0] LEVEL_THRESHOLD = 8'd128;

    localparam logic [SLOT_W-1:0] LAST_SLOT_1BPP = 3'd7;
    localparam logic [SLOT_W-1:0] LAST_SLOT_2BPP = 3'd3;
    localparam logic [SLOT_W-1:0] LAST_SLOT_4BPP = 3'd1;

    typedef enum logic [1:0] {
        DEPTH_1BPP = 2'd0,
        DEPTH_2BPP = 2'd1,
        DEPTH_4BPP = 2'd2,
        DEPTH_8BPP = 2'd3
    } t_depth_mode;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               line_end;
    } t_pix_in;

    typedef struct packed {
        logic [PIXEL_W-1:0] packed_byte;
        logic               line_done;
    } t_pix_out;

endpackage : gpdp_pkg

`default_nettype wire

@@ rtl/gray_pixel_depth_packer.sv @@
// Top level of the gray pixel depth packer: packs shadow pixels into LCD bytes.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------
//   in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_pix_in)
//   out     | output    | o_out_valid / i_out_stall  | o_out_data (t_pix_out)
//   cfg     | input     | i_cfg_wr_en                | i_cfg_wr_data (depth_mode)
//
// One pixel per cycle while o_in_stall is low; the packed byte is computed combinationally from
// the pixel that completes it and registered into the output register, or into the skid stage.
// Synchronous active-low reset clears depth mode, accumulator, slot count and valids.
// An output register plus a one-entry skid stage take one more byte-producing transfer
// after the output stalls; pixels that only fill slots keep flowing;
// o_in_stall rises only when the skid is full.
`timescale 1ns / 1ps
`default_nettype none

module gray_pixel_depth_packer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [1:0]        i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire gpdp_pkg::t_pix_in  i_in_data,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      gpdp_pkg::t_pix_out o_out_data
);
    import gpdp_pkg::*;

    t_depth_mode         r_depth_mode;
    logic [PIXEL_W-1:0]  r_acc;
    logic [PIXEL_W-1:0]  n_acc;
    logic [SLOT_W-1:0]   r_slot_count;
    logic [SLOT_W-1:0]   n_slot_count;
    t_pix_out            r_out;
    logic                r_out_valid;
    t_pix_out            r_skid;
    logic                r_skid_valid;

    logic [PIXEL_W-1:0]  acc_sum;
    logic                emit;
    logic                in_xfer;
    logic                out_xfer;
    t_pix_out            result;

    assign o_in_stall  = r_skid_valid;
    assign in_xfer     = i_in_valid && !r_skid_valid;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        acc_sum = r_acc;
        emit    = 1'b0;
        unique case (r_depth_mode)
            DEPTH_1BPP: begin
                if (i_in_data.pixel < LEVEL_THRESHOLD) begin
                    acc_sum = r_acc | (8'h01 << r_slot_count);
                end
                emit = (r_slot_count >= LAST_SLOT_1BPP) || i_in_data.line_end;
            end
            DEPTH_2BPP: begin
                acc_sum = r_acc | ({6'b0, i_in_data.pixel[7:6]} << {r_slot_count[1:0], 1'b0});
                emit    = (r_slot_count >= LAST_SLOT_2BPP) || i_in_data.line_end;
            end
            DEPTH_4BPP: begin
                if (r_slot_count[0] == 1'b0) begin
                    acc_sum = r_acc | {4'b0, i_in_data.pixel[7:4]};
                end else begin
                    acc_sum = r_acc | (i_in_data.pixel & 8'hF0);
                end
                emit = (r_slot_count >= LAST_SLOT_4BPP) || i_in_data.line_end;
            end
            DEPTH_8BPP: begin
                acc_sum = i_in_data.pixel;
                emit    = 1'b1;
            end
            default: begin
                acc_sum = r_acc;
                emit    = 1'b0;
            end
        endcase
        result.packed_byte = acc_sum;
        result.line_done   = i_in_data.line_end;

        n_acc        = r_acc;
        n_slot_count = r_slot_count;
        if (in_xfer) begin
            if (emit) begin
                n_acc        = '0;
                n_slot_count = '0;
            end else begin
                n_acc        = acc_sum;
                n_slot_count = r_slot_count + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= DEPTH_1BPP;
            r_acc        <= '0;
            r_slot_count <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_depth_mode <= t_depth_mode'(i_cfg_wr_data);
            end
            r_acc        <= n_acc;
            r_slot_count <= n_slot_count;
        end
    end

    // advance the output register from the skid or the new result; hold into the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_xfer) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_xfer && emit;
                end
            end else if (in_xfer && emit) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer && emit) begin
                r_out <= result;
            end
        end else if (in_xfer && emit) begin
            r_skid <= result;
        end
    end

endmodule : gray_pixel_depth_packer

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the gray pixel depth packer at every depth mode.
`timescale 1ns / 1ps

module testbench;
    import gpdp_pkg::*;

    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned RUN_ITEMS     = 64;
    localparam int unsigned HOLD_OFF_LEN  = 300;

    class pack_scoreboard;
        t_depth_mode        depth;
        logic [7:0]         acc;
        logic [2:0]         slots;
        t_pix_out           expected_bytes[$];
        int unsigned        errors;

        function new();
            depth  = DEPTH_1BPP;
            acc    = '0;
            slots  = '0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        function void note_pixel(t_pix_in px);
            logic [7:0] nxt;
            logic [2:0] end_slot;
            logic [2:0] pos;
            t_pix_out   res;
            res.packed_byte = px.pixel;
            res.line_done   = px.line_end;
            if (depth == DEPTH_8BPP) begin
                expected_bytes.push_back(res);
                acc   = '0;
                slots = '0;
                return;
            end
            nxt = acc;
            case (depth)
                DEPTH_1BPP: begin
                    end_slot = LAST_SLOT_1BPP;
                    pos      = slots;
                    if (px.pixel < LEVEL_THRESHOLD) nxt[pos] = 1'b1;
                end
                DEPTH_2BPP: begin
                    end_slot = LAST_SLOT_2BPP;
                    pos      = slots & 3'd3;
                    nxt      = nxt | ({6'b0, px.pixel[7:6]} << (2 * pos));
                end
                default: begin
                    end_slot = LAST_SLOT_4BPP;
                    pos      = slots & 3'd1;
                    if (pos == 3'd0) nxt = nxt | {4'b0, px.pixel[7:4]};
                    else             nxt = nxt | {px.pixel[7:4], 4'b0};
                end
            endcase
            if (slots >= end_slot || px.line_end) begin
                res.packed_byte = nxt;
                expected_bytes.push_back(res);
                acc   = '0;
                slots = '0;
            end else begin
                acc   = nxt;
                slots = slots + 3'd1;
            end
        endfunction

        function void check_byte(t_pix_out got);
            t_pix_out want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer: expected none, actual byte=%h line_done=%b",
                         $time, got.packed_byte, got.line_done);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.packed_byte !== want.packed_byte) begin
                errors++;
                $display("%0t: packed_byte: expected %h, actual %h",
                         $time, want.packed_byte, got.packed_byte);
            end
            if (got.line_done !== want.line_done) begin
                errors++;
                $display("%0t: line_done: expected %b, actual %b",
                         $time, want.line_done, got.line_done);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [1:0] i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_stall;
    t_pix_in    i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_pix_out   o_out_data;

    pack_scoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    int unsigned    hold_off_req;
    int unsigned    stall_left;

    gray_pixel_depth_packer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_byte(o_out_data);
    end

    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req > 0) begin
                stall_left   = hold_off_req;
                hold_off_req = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("gray_pixel_depth_packer: mismatch");
        $finish;
    end

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127 + 8'($urandom_range(1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] pix, input logic le);
        t_pix_in item;
        item.pixel    = pix;
        item.line_end = le;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_pixel(item);
    endtask

    task automatic wait_drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_depth(input t_depth_mode d);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d;
        @(posedge i_clk);
        sb.depth = d;
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_run(input int unsigned n_items);
        int unsigned sent;
        int unsigned run_len;
        int unsigned k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                run_len = ($urandom_range(7) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 12);
                for (k = 0; k < run_len; k++) send_pixel(random_pixel(), k == run_len - 1);
                sent += run_len;
            end else begin
                send_pixel(random_pixel(), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned ph;
        int unsigned seg;
        t_depth_mode mode;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = DEPTH_1BPP;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        send_idle_pct = 8;
        recv_idle_pct = 61;
        hold_off_req  = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // threshold edges, full group, then a flushed partial group
        write_depth(DEPTH_1BPP);
        send_pixel(8'd0, 1'b0);   send_pixel(8'd255, 1'b0);
        send_pixel(8'd127, 1'b0); send_pixel(8'd128, 1'b0);
        send_pixel(8'd1, 1'b0);   send_pixel(8'd254, 1'b0);
        send_pixel(8'd127, 1'b0); send_pixel(8'd128, 1'b0);
        send_pixel(8'd10, 1'b0);  send_pixel(8'd200, 1'b1);
        wait_drain();
        write_depth(DEPTH_2BPP);
        send_pixel(8'hC0, 1'b0); send_pixel(8'h80, 1'b0);
        send_pixel(8'h40, 1'b0); send_pixel(8'h3F, 1'b0);
        send_pixel(8'hFF, 1'b1);
        wait_drain();
        write_depth(DEPTH_4BPP);
        send_pixel(8'h0F, 1'b0); send_pixel(8'hF0, 1'b0);
        send_pixel(8'hAB, 1'b1);
        wait_drain();
        write_depth(DEPTH_8BPP);
        send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b1);
        // switch depth with a group partly filled
        wait_drain();
        write_depth(DEPTH_1BPP);
        send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b0); send_pixel(8'd5, 1'b0);
        wait_drain();
        write_depth(DEPTH_4BPP);
        send_pixel(8'hFF, 1'b0);
        // drop a partial group on passthrough
        wait_drain();
        write_depth(DEPTH_2BPP);
        send_pixel(8'hFF, 1'b0);
        wait_drain();
        write_depth(DEPTH_8BPP);
        send_pixel(8'h5A, 1'b0);

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 8;  recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (seg = 0; seg < 8; seg++) begin
                mode = (seg < 4) ? t_depth_mode'((seg + ph) % 4)
                                 : t_depth_mode'($urandom_range(3));
                wait_drain();
                write_depth(mode);
                if (ph == 0 && seg == 2) hold_off_req = HOLD_OFF_LEN;
                send_random_run(RUN_ITEMS);
            end
        end

        wait_drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("gray_pixel_depth_packer: match");
        end else begin
            $display("gray_pixel_depth_packer: mismatch");
        end
        $finish;
    end

endmodule
